>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion wrappers for the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while reset is released
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// types and constants shared by the bit field reader modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfr_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    localparam int unsigned FIELD_BITS   = 64;
    localparam int unsigned WINDOW_BYTES = 9;
    localparam int unsigned WINDOW_BITS  = WINDOW_BYTES * 8;
    localparam int unsigned IN_TDATA_W   = 40;
    localparam int unsigned OUT_TDATA_W  = 80;

    // largest field a read may take
    localparam logic [6:0] MAX_BIT_COUNT = 7'd64;
    // last step of the byte fetch sequence
    localparam logic [3:0] LAST_STEP     = 4'(WINDOW_BYTES);

    // fetched window handed from the sequencer to the output formatter
    typedef struct packed {
        logic                   valid;
        logic [WINDOW_BITS-1:0] window;
        logic [2:0]             off;
        logic [6:0]             n;
        logic                   swap;
        logic [14:0]            remaining;
        logic                   overrun;
    } t_fmt_req;

endpackage

>>> rtl/core/bfr_store.sv
// ----------------------------------------------------------------------------
// bfr_store
// single-port byte store with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfr_store #(
    parameter int unsigned DEPTH = 2048,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // one access per cycle, write or read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bfr_engine.sv
// ----------------------------------------------------------------------------
// bfr_engine
// item decode, head and capacity, byte fetch sequencer for reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfr_engine #(
    parameter int unsigned STORE_BYTES = 2048,
    localparam int unsigned AW         = $clog2(STORE_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [10:0]        i_byte_address,
    input  logic [7:0]         i_byte_value,
    input  logic [11:0]        i_byte_count,
    input  logic [6:0]         i_bit_count,
    input  logic               i_swap_bytes,
    output logic               o_mem_en,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_addr,
    output logic [7:0]         o_mem_wdata,
    input  logic [7:0]         i_mem_rdata,
    output bfr_pkg::t_fmt_req  o_req,
    input  logic               i_req_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DONE
    } t_state;

    localparam logic [13:0] STORE_LIMIT = 14'(STORE_BYTES);

    t_state     r_state;
    logic [3:0] r_step;
    logic [14:0] r_head;
    logic [11:0] r_cap_bytes;
    logic [12:0] r_idx;
    logic        r_pend_ok;
    logic [bfr_pkg::WINDOW_BITS-1:0] r_window;
    logic [2:0]  r_off;
    logic [6:0]  r_n;
    logic        r_swap;
    logic [14:0] r_rem;
    logic        r_over;

    logic        accept;
    logic [6:0]  n_eff;
    logic [15:0] end_pos;
    logic [14:0] cap_bits;
    logic        over;
    logic [14:0] new_head;
    logic        load_ok;
    logic        byte_ok;
    logic        fetching;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // head advance for an incoming read, clamped at the capacity
    assign n_eff    = (i_bit_count > bfr_pkg::MAX_BIT_COUNT) ? bfr_pkg::MAX_BIT_COUNT
                                                             : i_bit_count;
    assign cap_bits = {r_cap_bytes, 3'b000};
    assign end_pos  = {1'b0, r_head} + 16'(n_eff);
    assign over     = end_pos > {1'b0, cap_bits};
    assign new_head = over ? cap_bits : end_pos[14:0];

    // load lands only inside the store
    assign load_ok = ({3'b000, i_byte_address} < STORE_LIMIT);

    // stream byte exists only below capacity and inside the store
    assign byte_ok  = ({1'b0, r_idx} < STORE_LIMIT) && (r_idx < {1'b0, r_cap_bytes});
    assign fetching = (r_state == ST_FETCH) && (r_step != bfr_pkg::LAST_STEP);

    // shared memory port: loads while idle, fetches while busy
    always_comb begin
        o_mem_wdata = i_byte_value;
        if (r_state == ST_FETCH) begin
            o_mem_en   = fetching && byte_ok;
            o_mem_we   = 1'b0;
            o_mem_addr = r_idx[AW-1:0];
        end else begin
            o_mem_en   = accept && (i_kind == bfr_pkg::KIND_LOAD) && load_ok;
            o_mem_we   = 1'b1;
            o_mem_addr = AW'(i_byte_address);
        end
    end

    // request to the formatter
    always_comb begin
        o_req.valid     = (r_state == ST_DONE);
        o_req.window    = r_window;
        o_req.off       = r_off;
        o_req.n         = r_n;
        o_req.swap      = r_swap;
        o_req.remaining = r_rem;
        o_req.overrun   = r_over;
    end

    // sequencer state, head and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_head      <= '0;
            r_cap_bytes <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (bfr_pkg::t_kind'(i_kind))
                            bfr_pkg::KIND_START: begin
                                r_cap_bytes <= i_byte_count;
                                r_head      <= '0;
                            end
                            bfr_pkg::KIND_READ: begin
                                r_head  <= new_head;
                                r_state <= ST_FETCH;
                                r_step  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FETCH: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == bfr_pkg::LAST_STEP) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_req_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // read payload capture and window assembly
    always_ff @(posedge i_clk) begin
        if (accept && (i_kind == bfr_pkg::KIND_READ)) begin
            r_idx  <= {1'b0, r_head[14:3]};
            r_off  <= r_head[2:0];
            r_n    <= n_eff;
            r_swap <= i_swap_bytes;
            r_rem  <= cap_bits - new_head;
            r_over <= over;
        end else if (r_state == ST_FETCH) begin
            r_idx     <= r_idx + 13'd1;
            r_pend_ok <= byte_ok;
            // byte issued last cycle enters at the top of the window
            if (r_step != 4'd0) begin
                r_window <= {(r_pend_ok ? i_mem_rdata : 8'h00),
                             r_window[bfr_pkg::WINDOW_BITS-1:8]};
            end
        end
    end

endmodule

>>> rtl/core/bfr_format.sv
// ----------------------------------------------------------------------------
// bfr_format
// bit alignment, width mask, byte swap and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfr_format (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfr_pkg::t_fmt_req i_req,
    output logic              o_ready,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [63:0]       o_field_value,
    output logic [14:0]       o_remaining_bits,
    output logic              o_overrun
);

    logic        r_valid;
    logic [63:0] r_value;
    logic [14:0] r_rem;
    logic        r_over;

    logic [63:0] aligned;
    logic [63:0] masked;
    logic [63:0] swapped;
    logic [3:0]  nbytes;
    logic [3:0]  src;

    // first stream bit down to bit zero
    assign aligned = i_req.window[i_req.off +: bfr_pkg::FIELD_BITS];

    // drop bits past the requested width
    always_comb begin
        for (int i = 0; i < bfr_pkg::FIELD_BITS; i++) begin
            masked[i] = aligned[i] && (7'(i) < i_req.n);
        end
    end

    // reverse the low ceil(n/8) bytes
    assign nbytes = 4'((8'(i_req.n) + 8'd7) >> 3);
    always_comb begin
        swapped = '0;
        src     = '0;
        for (int j = 0; j < 8; j++) begin
            src = nbytes - 4'd1 - 4'(j);
            if (4'(j) < nbytes) begin
                swapped[j*8 +: 8] = masked[src[2:0]*8 +: 8];
            end
        end
    end

    assign o_ready = !r_valid || i_tready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_req.valid) begin
            r_value <= i_req.swap ? swapped : masked;
            r_rem   <= i_req.remaining;
            r_over  <= i_req.overrun;
        end
    end

    assign o_tvalid         = r_valid;
    assign o_field_value    = r_value;
    assign o_remaining_bits = r_rem;
    assign o_overrun        = r_over;

endmodule

>>> rtl/core/lsb_first_bit_field_reader.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_field_reader
// reads lsb-first bit fields of 1 to 64 bits from a loaded packet byte store
// ----------------------------------------------------------------------------
// usage
//   slave stream: tuser picks the item kind (load byte, start, read field).
//   a load writes one byte of the packet, a start sets the capacity in bytes
//   and clears the bit head, a read takes the next bit_count bits.
//   only a read gives a transfer on the master stream: the field value, the
//   bits left after the read, and tuser set when the read ran past capacity
//   (missing bits are zero, the head stops at the capacity).
// sequence
//   load, start and ignored kinds leave the sequencer idle, ready for more.
//   a read holds the input side until its result is handed on: nine byte
//   fetches go through the single store port, the last read data enters the
//   window, the window passes to the output register and the sequencer
//   returns to idle.
// reset and stall
//   reset clears head and capacity and empties the output register; the byte
//   store keeps no reset, bytes must be loaded before they are read.
//   a stalled master holds its result; loads and starts are still taken, a
//   further read finishes its fetch and waits until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_first_bit_field_reader #(
    parameter int unsigned STORE_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // byte_address[10:0], byte_value[18:11], byte_count[30:19],
    // bit_count[37:31], swap_bytes[38], zero[39]
    input  logic [39:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // field_value[63:0], remaining_bits[78:64], zero[79]
    output logic [79:0] m_axis_tdata,
    // overrun[0]
    output logic        m_axis_tuser
);

    `include "assert_macros.svh"

    localparam int unsigned AW = $clog2(STORE_BYTES);

    logic              mem_en;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;
    bfr_pkg::t_fmt_req fmt_req;
    logic              fmt_ready;
    logic [63:0]       field_value;
    logic [14:0]       remaining_bits;

    // packet byte store
    bfr_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // decode and fetch sequencer
    bfr_engine #(
        .STORE_BYTES (STORE_BYTES)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_kind         (s_axis_tuser),
        .i_byte_address (s_axis_tdata[10:0]),
        .i_byte_value   (s_axis_tdata[18:11]),
        .i_byte_count   (s_axis_tdata[30:19]),
        .i_bit_count    (s_axis_tdata[37:31]),
        .i_swap_bytes   (s_axis_tdata[38]),
        .o_mem_en       (mem_en),
        .o_mem_we       (mem_we),
        .o_mem_addr     (mem_addr),
        .o_mem_wdata    (mem_wdata),
        .i_mem_rdata    (mem_rdata),
        .o_req          (fmt_req),
        .i_req_ready    (fmt_ready)
    );

    // alignment, swap and output register
    bfr_format u_format (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (fmt_req),
        .o_ready          (fmt_ready),
        .o_tvalid         (m_axis_tvalid),
        .i_tready         (m_axis_tready),
        .o_field_value    (field_value),
        .o_remaining_bits (remaining_bits),
        .o_overrun        (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, remaining_bits, field_value};

    // checks

    // an overrun leaves the head at the capacity, so nothing remains
    `ASSERT_CLK(a_overrun_empty, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[78:64] == 15'd0, "overrun with bits remaining")

    // a read holds the input side while it fetches
    `ASSERT_CLK(a_read_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == bfr_pkg::KIND_READ) |=> !s_axis_tready, "input taken during a read")

    // coming out of reset the block is idle with no pending result
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> s_axis_tready && !m_axis_tvalid, "not idle after reset")

    // a read never completes in the cycle after its acceptance
    `ASSERT_CLK(a_no_early_result, i_clk, i_rst_n, !m_axis_tvalid && s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid, "result without fetch")

endmodule
